// File: rtl/unique_key_stack_with_sort_assert.svh
// assertion macros for the key stack block
`ifndef UNIQUE_KEY_STACK_WITH_SORT_ASSERT_SVH
`define UNIQUE_KEY_STACK_WITH_SORT_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define UKSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UKSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ukss_pkg.sv
package ukss_pkg;

    // operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_SORT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

// File: rtl/ukss_mem.sv
module ukss_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 26,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/unique_key_stack_with_sort.sv
// Bounded stack of {key, value} entries with duplicate-key refusal and sort.
// Command channel: drive i_operation, i_entry_key, i_entry_value with start;
// a command is taken at a clock edge where start is high and busy is low.
// Result channel: o_strobe is high for exactly one cycle with o_status,
// o_entry_count, o_top_valid, o_top_key and o_top_value; the receiver must
// take it then, there is no back pressure. busy stays high from the accepted
// command until the strobe cycle, so one command is in flight at a time.
// A push scans the stored keys for a duplicate, stopping at the first match
// and scanning all of them when the key is new. The single read port of the
// entry memory shapes the work: the search reads one entry per cycle and the
// sort is a series of bubble passes, each one entry shorter than the last.
// Reset clears the entry count and the sequencer; memory contents are not
// cleared, as only entries below the count are ever used.
`include "unique_key_stack_with_sort_assert.svh"

module unique_key_stack_with_sort #(
    parameter int STACK_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int VALUE_BITS  = 10,
    localparam int CW = $clog2(STACK_DEPTH + 1),
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_operation,
    input  logic [KEY_BITS-1:0]   i_entry_key,
    input  logic [VALUE_BITS-1:0] i_entry_value,
    output logic                  o_strobe,
    output logic [1:0]            o_status,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_top_valid,
    output logic [KEY_BITS-1:0]   o_top_key,
    output logic [VALUE_BITS-1:0] o_top_value
);

    localparam int EW = KEY_BITS + VALUE_BITS;
    // memory word: {slot at sort start, key, value}
    localparam int MW = EW + AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_DECIDE,
        S_SORT_LOAD,
        S_SORT_STEP,
        S_SORT_END,
        S_TOP,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [AW-1:0]         r_last;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [MW-1:0]         r_carry;
    logic                  r_first;
    logic                  r_dup;
    logic [1:0]            r_status;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [MW-1:0]         mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [MW-1:0]         mem_rd_data;

    logic [CW-1:0]         idx_next;
    logic                  full;
    logic                  key_hit;
    logic                  carry_up;
    logic [AW-1:0]         rd_tag;
    logic [MW-1:0]         rd_entry;

    assign busy     = (r_state != S_IDLE);
    assign idx_next = r_idx + CW'(1);
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign key_hit  = (mem_rd_data[EW-1:VALUE_BITS] == r_key);
    // first pass tags each entry with the slot it was read from
    assign rd_tag   = r_first ? r_idx[AW-1:0] : mem_rd_data[MW-1:EW];
    assign rd_entry = {rd_tag, mem_rd_data[EW-1:0]};
    // carried entry rises past a larger value, or an equal one from a higher slot
    assign carry_up = (r_carry[VALUE_BITS-1:0] < mem_rd_data[VALUE_BITS-1:0]) ||
                      ((r_carry[VALUE_BITS-1:0] == mem_rd_data[VALUE_BITS-1:0]) &&
                       (r_carry[MW-1:EW] < rd_tag));

    // entry memory
    ukss_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // memory addressing per sequencer step
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_idx[AW-1:0];
        mem_wr_data = {AW'(0), r_key, r_val};
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                mem_rd_en = start;
            end
            S_SRCH, S_SORT_LOAD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_next[AW-1:0];
            end
            S_DECIDE: begin
                mem_wr_en   = !r_dup && !full;
                mem_wr_addr = r_count[AW-1:0];
            end
            S_SORT_STEP: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_idx[AW-1:0] - AW'(1);
                mem_wr_data = carry_up ? rd_entry : r_carry;
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_next[AW-1:0];
            end
            S_SORT_END: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_last;
                mem_wr_data = r_carry;
                mem_rd_en   = 1'b1;
            end
            S_TOP: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_count[AW-1:0] - AW'(1);
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // sequencer, count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key    <= i_entry_key;
                        r_val    <= i_entry_value;
                        r_dup    <= 1'b0;
                        r_idx    <= '0;
                        r_first  <= 1'b1;
                        r_status <= ukss_pkg::ST_DONE;
                        case (i_operation)
                            ukss_pkg::OP_PUSH: begin
                                r_state <= (r_count == '0) ? S_DECIDE : S_SRCH;
                            end
                            ukss_pkg::OP_POP: begin
                                if (r_count == '0) begin
                                    r_status <= ukss_pkg::ST_EMPTY;
                                end else begin
                                    r_count <= r_count - CW'(1);
                                end
                                r_state <= S_TOP;
                            end
                            ukss_pkg::OP_SORT: begin
                                r_last  <= r_count[AW-1:0] - AW'(1);
                                r_state <= (r_count <= CW'(1)) ? S_TOP : S_SORT_LOAD;
                            end
                            default: begin
                                r_state <= S_TOP;
                            end
                        endcase
                    end
                end
                // duplicate search, one stored key per cycle
                S_SRCH: begin
                    if (key_hit) begin
                        r_dup   <= 1'b1;
                        r_state <= S_DECIDE;
                    end else if (idx_next == r_count) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= idx_next;
                    end
                end
                S_DECIDE: begin
                    if (r_dup) begin
                        r_status <= ukss_pkg::ST_DUP;
                    end else if (full) begin
                        r_status <= ukss_pkg::ST_FULL;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_TOP;
                end
                // bubble pass: the smallest value rises to r_last
                S_SORT_LOAD: begin
                    r_carry <= rd_entry;
                    r_idx   <= CW'(1);
                    r_state <= S_SORT_STEP;
                end
                S_SORT_STEP: begin
                    if (!carry_up) begin
                        r_carry <= rd_entry;
                    end
                    if (r_idx == CW'(r_last)) begin
                        r_state <= S_SORT_END;
                    end else begin
                        r_idx <= idx_next;
                    end
                end
                S_SORT_END: begin
                    r_first <= 1'b0;
                    if (r_last == AW'(1)) begin
                        r_state <= S_TOP;
                    end else begin
                        r_last  <= r_last - AW'(1);
                        r_idx   <= '0;
                        r_state <= S_SORT_LOAD;
                    end
                end
                S_TOP: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    o_strobe      <= 1'b1;
                    o_status      <= r_status;
                    o_entry_count <= r_count;
                    o_top_valid   <= (r_count != '0);
                    if (r_count != '0) begin
                        o_top_key   <= mem_rd_data[EW-1:VALUE_BITS];
                        o_top_value <= mem_rd_data[VALUE_BITS-1:0];
                    end else begin
                        o_top_key   <= '0;
                        o_top_value <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `UKSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
    `UKSS_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result beat lasted more than one cycle")
    `UKSS_ASSERT_SAME(a_idle_no_write, r_state == S_IDLE, !mem_wr_en, "memory written while idle")
    `UKSS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(STACK_DEPTH), "entry count beyond depth")

endmodule

// File: bench/unique_key_stack_with_sort_tb.sv
`timescale 1ns / 100ps

module unique_key_stack_with_sort_tb;

    localparam int DEPTH      = 16;
    localparam int KEY_W      = 16;
    localparam int VAL_W      = 10;
    localparam int CNT_W      = 5;
    localparam int POOL_SIZE  = 32;
    localparam int RAND_ITEMS = 450;
    localparam int STALL_MAX  = 4000;
    localparam int DRAIN_WAIT = 200;

    // operation code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
        logic             top_valid;
        logic [KEY_W-1:0] top_key;
        logic [VAL_W-1:0] top_value;
    } t_stack_result;

    // mirror of the stack contents and the results it should produce
    class t_stack_scoreboard;
        logic [KEY_W-1:0] keys[DEPTH];
        logic [VAL_W-1:0] vals[DEPTH];
        int unsigned      fill;
        t_stack_result    pending_results[$];
        int               errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        // reorder so values descend bottom to top, ties kept in top-first scan order
        function void sort_by_value();
            logic [KEY_W-1:0] ks[DEPTH];
            logic [VAL_W-1:0] vs[DEPTH];
            logic [KEY_W-1:0] k;
            logic [VAL_W-1:0] v;
            int               j;
            for (int i = 0; i < fill; i++) begin
                ks[i] = keys[fill - 1 - i];
                vs[i] = vals[fill - 1 - i];
            end
            for (int i = 1; i < fill; i++) begin
                k = ks[i];
                v = vs[i];
                j = i;
                while (j > 0 && vs[j - 1] < v) begin
                    ks[j] = ks[j - 1];
                    vs[j] = vs[j - 1];
                    j--;
                end
                ks[j] = k;
                vs[j] = v;
            end
            for (int i = 0; i < fill; i++) begin
                keys[i] = ks[i];
                vals[i] = vs[i];
            end
        endfunction

        // apply one accepted command and queue the result it causes
        function void note_command(logic [1:0] op, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] val);
            t_stack_result r;
            bit            found;
            r.status = ukss_pkg::ST_DONE;
            found    = 1'b0;
            case (op)
                ukss_pkg::OP_PUSH: begin
                    for (int i = 0; i < fill; i++)
                        if (keys[i] == key) found = 1'b1;
                    if (found) begin
                        r.status = ukss_pkg::ST_DUP;
                    end else if (fill >= DEPTH) begin
                        r.status = ukss_pkg::ST_FULL;
                    end else begin
                        keys[fill] = key;
                        vals[fill] = val;
                        fill++;
                    end
                end
                ukss_pkg::OP_POP: begin
                    if (fill == 0) r.status = ukss_pkg::ST_EMPTY;
                    else fill--;
                end
                ukss_pkg::OP_SORT: sort_by_value();
                default: ;
            endcase
            r.entry_count = fill[CNT_W-1:0];
            if (fill > 0) begin
                r.top_valid = 1'b1;
                r.top_key   = keys[fill - 1];
                r.top_value = vals[fill - 1];
            end else begin
                r.top_valid = 1'b0;
                r.top_key   = '0;
                r.top_value = '0;
            end
            pending_results = {pending_results, r};
        endfunction

        task check_result(t_stack_result got);
            t_stack_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result", 32'(got.entry_count), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report("status", 32'(got.status), 32'(want.status));
                if (got.entry_count !== want.entry_count)
                    report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
                if (got.top_valid !== want.top_valid)
                    report("top_valid", 32'(got.top_valid), 32'(want.top_valid));
                if (got.top_key !== want.top_key)
                    report("top_key", 32'(got.top_key), 32'(want.top_key));
                if (got.top_value !== want.top_value)
                    report("top_value", 32'(got.top_value), 32'(want.top_value));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_operation;
    logic [KEY_W-1:0] i_entry_key;
    logic [VAL_W-1:0] i_entry_value;
    logic             o_strobe;
    logic [1:0]       o_status;
    logic [CNT_W-1:0] o_entry_count;
    logic             o_top_valid;
    logic [KEY_W-1:0] o_top_key;
    logic [VAL_W-1:0] o_top_value;

    t_stack_scoreboard sb = new();
    bit                idle_on = 1'b1;
    int                stall_cycles = 0;
    logic [KEY_W-1:0]  key_pool[POOL_SIZE];

    unique_key_stack_with_sort #(
        .STACK_DEPTH(DEPTH),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VAL_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_entry_key  (i_entry_key),
        .i_entry_value(i_entry_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_entry_count(o_entry_count),
        .o_top_valid  (o_top_valid),
        .o_top_key    (o_top_key),
        .o_top_value  (o_top_value)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result beat is checked before the command taken on the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result({o_status, o_entry_count, o_top_valid,
                                 o_top_key, o_top_value});
            if (start && !busy)
                sb.note_command(i_operation, i_entry_key, i_entry_value);
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (o_strobe || (start && !busy)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("FAIL unique_key_stack_with_sort");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task send_cmd(logic [1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        while (idle_on && $urandom_range(0, 99) < 38) begin
            start         <= 1'b0;
            i_operation   <= 2'($urandom);
            i_entry_key   <= KEY_W'($urandom);
            i_entry_value <= VAL_W'($urandom);
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_entry_key   <= key;
        i_entry_value <= val;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        int               push_weight;
        int               r;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_operation   = ukss_pkg::OP_PUSH;
        i_entry_key   = '0;
        i_entry_value = '0;
        push_weight   = 50;

        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty stack corner cases
        send_cmd(OP_UNUSED, 16'h5555, 10'h155);
        send_cmd(ukss_pkg::OP_SORT, '0, '0);
        send_cmd(ukss_pkg::OP_POP, '1, '1);
        // field extremes, duplicate refusal, equal values in sort
        send_cmd(ukss_pkg::OP_PUSH, 16'h0000, 10'h000);
        send_cmd(ukss_pkg::OP_PUSH, 16'hFFFF, 10'h3FF);
        send_cmd(ukss_pkg::OP_PUSH, 16'hFFFF, 10'h005);
        send_cmd(ukss_pkg::OP_PUSH, 16'h1234, 10'h3FF);
        send_cmd(ukss_pkg::OP_PUSH, 16'h00AA, 10'h000);
        send_cmd(ukss_pkg::OP_SORT, '0, '0);
        send_cmd(ukss_pkg::OP_POP, '0, '0);
        send_cmd(OP_UNUSED, '1, '1);
        // fill to the bound, then refuse a new key and a duplicate
        for (int i = 0; i < 13; i++)
            send_cmd(ukss_pkg::OP_PUSH, 16'h0100 + 16'(i), VAL_W'($urandom));
        send_cmd(ukss_pkg::OP_PUSH, 16'hBEEF, 10'h2AA);
        send_cmd(ukss_pkg::OP_PUSH, 16'h0100, 10'h111);
        send_cmd(ukss_pkg::OP_SORT, '0, '0);

        // random: push bias moves between filling and draining phases
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) push_weight = $urandom_range(20, 85);
            idle_on = !(n >= 150 && n < 260);
            r = $urandom_range(0, 99);
            if (r < 3) op = OP_UNUSED;
            else if (r < 15) op = ukss_pkg::OP_SORT;
            else if ($urandom_range(0, 99) < push_weight) op = ukss_pkg::OP_PUSH;
            else op = ukss_pkg::OP_POP;
            if ($urandom_range(0, 3) == 0) key = KEY_W'($urandom);
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 2))
                0: val = VAL_W'($urandom_range(0, 7));
                1: val = VAL_W'($urandom);
                default: val = $urandom_range(0, 1) ? '1 : '0;
            endcase
            send_cmd(op, key, val);
        end
        start <= 1'b0;

        // let the last results arrive, then watch for stray beats
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("PASS unique_key_stack_with_sort");
        end else begin
            $display("FAIL unique_key_stack_with_sort");
        end
        $finish;
    end

endmodule
